### rtl/core/bsd130_pkg.sv
package bsd130_pkg;

    localparam int LfsrWidth    = 23;
    localparam int PayloadBytes = 16;
    localparam int PayloadBits  = PayloadBytes * 8;
    localparam int HalfBits     = PayloadBits / 2;

    localparam logic [LfsrWidth-1:0] LFSR_TAPS  = 23'h210125;
    localparam logic [7:0]           SKIP_FIRST = 8'hAA;
    localparam logic [7:0]           SKIP_END   = 8'hE1;

    localparam logic [1:0] SYNC_DATA = 2'd1;
    localparam logic [1:0] SYNC_OS   = 2'd2;

    typedef enum logic [1:0] {
        KIND_ERROR         = 2'd0,
        KIND_DATA_UNLOCKED = 2'd1,
        KIND_DATA          = 2'd2,
        KIND_ORDERED_SET   = 2'd3
    } block_kind_t;

    typedef logic [LfsrWidth-1:0] lfsr_t;

    typedef struct packed {
        logic  is_skip;
        logic  found;
        lfsr_t load_value;
    } skip_info_t;

    typedef struct packed {
        logic [PayloadBits-1:0][LfsrWidth-1:0] key;
        logic [LfsrWidth-1:0][LfsrWidth-1:0]   adv;
    } lfsr_masks_t;

    // each state bit tracked as a mask over the starting state bits
    function automatic lfsr_masks_t lfsr_masks();
        logic [LfsrWidth-1:0][LfsrWidth-1:0] s;
        lfsr_t       b;
        lfsr_masks_t m;
        for (int i = 0; i < LfsrWidth; i++)
        begin
            s[i] = lfsr_t'(1) << i;
        end
        for (int k = 0; k < PayloadBits; k++)
        begin
            b = s[LfsrWidth-1];
            m.key[k] = b;
            for (int i = LfsrWidth - 1; i > 0; i--)
            begin
                s[i] = s[i-1];
            end
            s[0] = '0;
            for (int i = 0; i < LfsrWidth; i++)
            begin
                if (LFSR_TAPS[i])
                begin
                    s[i] = s[i] ^ b;
                end
            end
        end
        m.adv = s;
        return m;
    endfunction

endpackage

### rtl/core/bsd130_in_if.sv
interface bsd130_in_if;
    import bsd130_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [1:0]            sync_header;
    logic [HalfBits-1:0]   payload_low;
    logic [HalfBits-1:0]   payload_high;

    modport source (
        output valid,
        output sync_header,
        output payload_low,
        output payload_high,
        input  ready
    );

    modport sink (
        input  valid,
        input  sync_header,
        input  payload_low,
        input  payload_high,
        output ready
    );
endinterface

### rtl/core/bsd130_out_if.sv
interface bsd130_out_if;
    import bsd130_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [1:0]            block_kind;
    logic                  is_skip_set;
    logic [HalfBits-1:0]   data_low;
    logic [HalfBits-1:0]   data_high;

    modport source (
        output valid,
        output block_kind,
        output is_skip_set,
        output data_low,
        output data_high,
        input  ready
    );

    modport sink (
        input  valid,
        input  block_kind,
        input  is_skip_set,
        input  data_low,
        input  data_high,
        output ready
    );
endinterface

### rtl/core/bsd130_lfsr.sv
module bsd130_lfsr (
    input  bsd130_pkg::lfsr_t                         state,
    output logic [bsd130_pkg::PayloadBits-1:0]        keystream,
    output bsd130_pkg::lfsr_t                         advanced
);
    import bsd130_pkg::*;

    localparam lfsr_masks_t Masks = lfsr_masks();

    always_comb
    begin
        for (int k = 0; k < PayloadBits; k++)
        begin
            keystream[k] = ^(state & Masks.key[k]);
        end
        for (int i = 0; i < LfsrWidth; i++)
        begin
            advanced[i] = ^(state & Masks.adv[i]);
        end
    end
endmodule

### rtl/core/bsd130_skip.sv
module bsd130_skip (
    input  logic [bsd130_pkg::PayloadBits-1:0] payload,
    output bsd130_pkg::skip_info_t             info
);
    import bsd130_pkg::*;

    // three zero bytes past the end for a marker near the tail
    logic [PayloadBytes+2:0][7:0] bytes;

    always_comb
    begin
        bytes = '0;
        for (int j = 0; j < PayloadBytes; j++)
        begin
            bytes[j] = payload[8*j +: 8];
        end
        info.is_skip    = (bytes[0] == SKIP_FIRST);
        info.found      = 1'b0;
        info.load_value = '0;
        // descending so the first marker wins
        for (int j = PayloadBytes - 1; j > 0; j--)
        begin
            if (bytes[j] == SKIP_END)
            begin
                info.found      = 1'b1;
                info.load_value = lfsr_t'({bytes[j+1], bytes[j+2], bytes[j+3]});
            end
        end
    end
endmodule

### rtl/core/block_sync_descrambler_130b_core.sv
// pipeline: an input beat passes through the input register, then the result register
// throughput: one block per cycle while the result side is not stalled; the descrambler state closes its loop
// through the 128-bit keystream network and the skip set marker search
// reset: asynchronous active low; descrambler state cleared to zero and unlocked,
// both pipeline registers emptied
module block_sync_descrambler_130b_core (
    input  logic          clk,
    input  logic          rst_n,
    bsd130_in_if.sink     blk_in,
    bsd130_out_if.source  blk_out
);
    import bsd130_pkg::*;

    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [1:0]             hdr_reg;
    logic [PayloadBits-1:0] payload_reg;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    block_kind_t            kind_reg;
    block_kind_t            kind_next;
    logic                   skip_reg;
    logic                   skip_next;
    logic [PayloadBits-1:0] data_reg;
    logic [PayloadBits-1:0] data_next;

    lfsr_t                  state_reg;
    lfsr_t                  state_next;
    logic                   locked_reg;
    logic                   locked_next;

    logic                   accept;
    logic                   fire;
    logic                   is_os;
    logic [PayloadBits-1:0] keystream;
    lfsr_t                  advanced;
    skip_info_t             skip_info;

    bsd130_lfsr u_lfsr (
        .state     (state_reg),
        .keystream (keystream),
        .advanced  (advanced)
    );

    bsd130_skip u_skip (
        .payload (payload_reg),
        .info    (skip_info)
    );

    assign fire         = in_valid_reg && (!out_valid_reg || blk_out.ready);
    assign blk_in.ready = !in_valid_reg || fire;
    assign accept       = blk_in.valid && blk_in.ready;
    assign is_os        = (hdr_reg == SYNC_OS);

    always_comb
    begin
        priority if (hdr_reg == SYNC_DATA)
        begin
            kind_next = locked_reg ? KIND_DATA : KIND_DATA_UNLOCKED;
        end
        else if (is_os)
        begin
            kind_next = KIND_ORDERED_SET;
        end
        else
        begin
            kind_next = KIND_ERROR;
        end

        skip_next   = is_os && skip_info.is_skip;
        data_next   = is_os ? payload_reg : (payload_reg ^ keystream);
        state_next  = state_reg;
        locked_next = locked_reg;
        if (fire)
        begin
            if (skip_next)
            begin
                locked_next = 1'b1;
                if (skip_info.found)
                begin
                    state_next = skip_info.load_value;
                end
            end
            else
            begin
                state_next = advanced;
            end
        end

        in_valid_next = accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
        out_valid_next = fire ? 1'b1 : (blk_out.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            locked_reg    <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
            locked_reg    <= locked_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hdr_reg     <= blk_in.sync_header;
            payload_reg <= {blk_in.payload_high, blk_in.payload_low};
        end
        if (fire)
        begin
            kind_reg <= kind_next;
            skip_reg <= skip_next;
            data_reg <= data_next;
        end
    end

    assign blk_out.valid       = out_valid_reg;
    assign blk_out.block_kind  = kind_reg;
    assign blk_out.is_skip_set = skip_reg;
    assign blk_out.data_low    = data_reg[HalfBits-1:0];
    assign blk_out.data_high   = data_reg[PayloadBits-1:HalfBits];

`ifndef SYNTHESIS
    a_skip_is_os: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && skip_reg |-> kind_reg == KIND_ORDERED_SET)
        else $error("skip set flagged on a block that is not an ordered set");

    a_skip_locks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && skip_reg |-> locked_reg)
        else $error("skip set delivered while descrambler unlocked");

    a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(locked_reg))
        else $error("descrambler lock dropped without reset");

    a_held_block: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !fire |=> in_valid_reg && $stable(payload_reg))
        else $error("waiting input block lost or overwritten");

    a_unlocked_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && locked_reg && $past(locked_reg) && $past(out_valid_reg)
        && !$past(fire) |-> kind_reg != KIND_DATA_UNLOCKED)
        else $error("unlocked data kind reported after lock");
`endif
endmodule

### sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bsd130_pkg::*;

    localparam int NumDirected = 25;
    localparam int NumRandom   = 1000;
    localparam int CalmTail    = 150;
    localparam int QuietLimit  = 2000;
    localparam int DrainCycles = 8;
    localparam int MaxReports  = 40;

    localparam logic [1:0] SyncErrLow  = 2'b00;
    localparam logic [1:0] SyncErrHigh = 2'b11;

    typedef struct packed {
        logic [1:0]          sync_header;
        logic [HalfBits-1:0] payload_low;
        logic [HalfBits-1:0] payload_high;
    } raw_block_t;

    typedef struct packed {
        block_kind_t         kind;
        logic                skip;
        logic [HalfBits-1:0] data_low;
        logic [HalfBits-1:0] data_high;
    } clear_block_t;

    typedef struct packed {
        logic [1:0]          sync_header;
        logic [HalfBits-1:0] payload_low;
        logic [HalfBits-1:0] payload_high;
        logic                typed;
        block_kind_t         kind;
        logic                skip;
    } directed_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bsd130_in_if  blk_in_bus ();
    bsd130_out_if blk_out_bus ();

    block_sync_descrambler_130b_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .blk_in  (blk_in_bus.sink),
        .blk_out (blk_out_bus.source)
    );

    always #6 clk = ~clk;

    // typed rows pass their bytes through untouched: the descrambler is at zero or
    // the block is an ordered set
    directed_row_t rows [NumDirected] = '{
        '{SYNC_DATA, 64'h0, 64'h0, 1'b1, KIND_DATA_UNLOCKED, 1'b0},
        '{SYNC_DATA, '1, '1, 1'b1, KIND_DATA_UNLOCKED, 1'b0},
        '{SyncErrLow, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
          1'b1, KIND_ERROR, 1'b0},
        '{SyncErrHigh, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
          1'b1, KIND_ERROR, 1'b0},
        '{SYNC_OS, 64'h0123_4567_89AB_CD1E, 64'hFEDC_BA98_7654_3210,
          1'b1, KIND_ORDERED_SET, 1'b0},
        '{SYNC_OS, 64'h1122_3344_5566_77AA, 64'hFFEE_DDCC_BBAA_9988,
          1'b1, KIND_ORDERED_SET, 1'b1},
        '{SYNC_DATA, '1, '1, 1'b1, KIND_DATA, 1'b0},
        '{SYNC_OS, 64'h0000_00FF_FFFF_E1AA, 64'h0, 1'b1, KIND_ORDERED_SET, 1'b1},
        '{SYNC_DATA, 64'h0, 64'h0, 1'b0, KIND_ERROR, 1'b0},
        '{SyncErrHigh, '1, '1, 1'b0, KIND_ERROR, 1'b0},
        '{SYNC_OS, 64'hFFFF_FFFF_FFFF_FFAB, '1, 1'b1, KIND_ORDERED_SET, 1'b0},
        '{SYNC_DATA, 64'h0, 64'h0, 1'b0, KIND_ERROR, 1'b0},
        '{SYNC_OS, 64'h0102_0304_0506_07AA, 64'h0809_0A0B_0C0D_0E0F,
          1'b1, KIND_ORDERED_SET, 1'b1},
        '{SYNC_DATA, 64'h0, 64'h0, 1'b0, KIND_ERROR, 1'b0},
        '{SYNC_OS, 64'h0000_0000_0000_00AA, 64'hE100_0000_0000_0000,
          1'b1, KIND_ORDERED_SET, 1'b1},
        '{SYNC_DATA, 64'hDEAD_BEEF_0BAD_F00D, '1, 1'b1, KIND_DATA, 1'b0},
        '{SYNC_OS, 64'h0000_0000_0000_00AA, 64'h81E1_0000_0000_0000,
          1'b1, KIND_ORDERED_SET, 1'b1},
        '{SYNC_DATA, 64'h0, 64'h0, 1'b0, KIND_ERROR, 1'b0},
        '{SYNC_OS, 64'h0000_0000_0000_00AA, 64'h3412_E100_0000_0000,
          1'b1, KIND_ORDERED_SET, 1'b1},
        '{SYNC_DATA, '1, '1, 1'b0, KIND_ERROR, 1'b0},
        '{SYNC_OS, 64'h0000_00E1_E1E1_E1AA, 64'h0000_0000_0000_E100,
          1'b1, KIND_ORDERED_SET, 1'b1},
        '{SYNC_DATA, 64'h0, 64'h0, 1'b0, KIND_ERROR, 1'b0},
        '{SYNC_OS, 64'h0000_0000_E1E1_E100, 64'h0, 1'b1, KIND_ORDERED_SET, 1'b0},
        '{SyncErrLow, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
          1'b0, KIND_ERROR, 1'b0},
        '{SYNC_DATA, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
          1'b0, KIND_ERROR, 1'b0}
    };

    lfsr_t        scr_state  = '0;
    logic         scr_locked = 1'b0;
    clear_block_t pending_blocks [$];

    logic        drv_typed = 1'b0;
    block_kind_t drv_kind  = KIND_ERROR;
    logic        drv_skip  = 1'b0;
    logic        calm      = 1'b0;
    int          src_gap_pct;
    int          sink_stall_pct;

    int mismatches   = 0;
    int beats_in     = 0;
    int beats_out    = 0;
    int quiet_cycles = 0;
    int kind_seen [4] = '{0, 0, 0, 0};
    int skips_seen   = 0;

    function automatic logic [HalfBits-1:0] keystream_half();
        logic [HalfBits-1:0] ks;
        logic                out_bit;
        ks = '0;
        for (int k = 0; k < HalfBits; k++)
        begin
            out_bit   = scr_state[LfsrWidth-1];
            ks[k]     = out_bit;
            scr_state = {scr_state[LfsrWidth-2:0], 1'b0};
            if (out_bit)
                scr_state = scr_state ^ LFSR_TAPS;
        end
        return ks;
    endfunction

    function automatic clear_block_t descramble(input raw_block_t b);
        clear_block_t            r;
        logic [PayloadBits+23:0] wide;
        logic [23:0]             load;
        logic                    hit;
        wide        = {24'h0, b.payload_high, b.payload_low};
        r.skip      = 1'b0;
        r.data_low  = b.payload_low;
        r.data_high = b.payload_high;
        case (b.sync_header)
            SYNC_DATA: r.kind = scr_locked ? KIND_DATA : KIND_DATA_UNLOCKED;
            SYNC_OS:   r.kind = KIND_ORDERED_SET;
            default:   r.kind = KIND_ERROR;
        endcase
        if (r.kind == KIND_ORDERED_SET)
        begin
            if (wide[7:0] == SKIP_FIRST)
            begin
                r.skip = 1'b1;
                hit    = 1'b0;
                for (int j = 1; j < PayloadBytes; j++)
                begin
                    if (!hit && wide[8*j +: 8] == SKIP_END)
                    begin
                        hit       = 1'b1;
                        load      = {wide[8*(j+1) +: 8], wide[8*(j+2) +: 8],
                                     wide[8*(j+3) +: 8]};
                        scr_state = load[LfsrWidth-1:0];
                    end
                end
                scr_locked = 1'b1;
            end
            else
            begin
                void'(keystream_half());
                void'(keystream_half());
            end
        end
        else
        begin
            r.data_low  = r.data_low ^ keystream_half();
            r.data_high = r.data_high ^ keystream_half();
        end
        return r;
    endfunction

    function automatic int burst_odds();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 40;
        endcase
    endfunction

    task automatic report_mismatch(input string field, input logic [HalfBits-1:0] want,
                                   input logic [HalfBits-1:0] got);
        mismatches++;
        if (mismatches <= MaxReports)
            $display("%0t ns: %s expected %h got %h", $time, field, want, got);
    endtask

    task automatic send_block(input raw_block_t b);
        blk_in_bus.valid        = 1'b1;
        blk_in_bus.sync_header  = b.sync_header;
        blk_in_bus.payload_low  = b.payload_low;
        blk_in_bus.payload_high = b.payload_high;
        @(posedge clk);
        while (!blk_in_bus.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic source_gap();
        if (!calm && $urandom_range(0, 99) < src_gap_pct)
        begin
            blk_in_bus.valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
    endtask

    // input beats feed the predictor before the result side is checked
    always @(posedge clk)
    begin
        clear_block_t want;
        clear_block_t got;
        logic         in_beat;
        logic         out_beat;
        in_beat  = rst_n && blk_in_bus.valid && blk_in_bus.ready;
        out_beat = rst_n && blk_out_bus.valid && blk_out_bus.ready;
        if (in_beat)
        begin
            want = descramble({blk_in_bus.sync_header, blk_in_bus.payload_low,
                               blk_in_bus.payload_high});
            if (drv_typed)
            begin
                want.kind      = drv_kind;
                want.skip      = drv_skip;
                want.data_low  = blk_in_bus.payload_low;
                want.data_high = blk_in_bus.payload_high;
            end
            pending_blocks.insert(pending_blocks.size(), want);
            beats_in++;
        end
        if (out_beat)
        begin
            got.kind      = block_kind_t'(blk_out_bus.block_kind);
            got.skip      = blk_out_bus.is_skip_set;
            got.data_low  = blk_out_bus.data_low;
            got.data_high = blk_out_bus.data_high;
            beats_out++;
            if (pending_blocks.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: unexpected result beat, expected none got kind %0d data %h_%h",
                         $time, got.kind, got.data_high, got.data_low);
            end
            else
            begin
                want = pending_blocks.pop_front();
                kind_seen[want.kind]++;
                if (want.skip)
                    skips_seen++;
                if (got.kind !== want.kind)
                    report_mismatch("block_kind", HalfBits'(want.kind),
                                    HalfBits'(blk_out_bus.block_kind));
                if (got.skip !== want.skip)
                    report_mismatch("is_skip_set", HalfBits'(want.skip),
                                    HalfBits'(blk_out_bus.is_skip_set));
                if (got.data_low !== want.data_low)
                    report_mismatch("data_low", want.data_low, got.data_low);
                if (got.data_high !== want.data_high)
                    report_mismatch("data_high", want.data_high, got.data_high);
            end
        end
        if (rst_n)
        begin
            if (in_beat || out_beat)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QuietLimit)
            begin
                $display("%0t ns: no beat for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, pending_blocks.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        blk_out_bus.ready = 1'b0;
        sink_stall_pct    = burst_odds();
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 99) < sink_stall_pct)
            begin
                blk_out_bus.ready = 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
            end
            blk_out_bus.ready = 1'b1;
            if ($urandom_range(0, 63) == 0)
                sink_stall_pct = burst_odds();
        end
    end

    initial
    begin
        raw_block_t             b;
        logic [PayloadBits-1:0] pl;
        int                     pick;
        int                     pos;
        blk_in_bus.valid        = 1'b0;
        blk_in_bus.sync_header  = '0;
        blk_in_bus.payload_low  = '0;
        blk_in_bus.payload_high = '0;
        src_gap_pct             = burst_odds();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
        begin
            drv_typed = rows[i].typed;
            drv_kind  = rows[i].kind;
            drv_skip  = rows[i].skip;
            send_block({rows[i].sync_header, rows[i].payload_low, rows[i].payload_high});
            source_gap();
        end
        drv_typed = 1'b0;

        for (int n = 0; n < NumRandom; n++)
        begin
            pl   = {$urandom, $urandom, $urandom, $urandom};
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                // skip set, mostly with a reload marker
                b.sync_header = SYNC_OS;
                pl[7:0]       = SKIP_FIRST;
                if ($urandom_range(0, 4) == 0)
                begin
                    for (int j = 1; j < PayloadBytes; j++)
                    begin
                        if (pl[8*j +: 8] == SKIP_END)
                            pl[8*j +: 8] = 8'h00;
                    end
                end
                else
                begin
                    pos              = $urandom_range(1, PayloadBytes - 1);
                    pl[8*pos +: 8]   = SKIP_END;
                end
            end
            else if (pick < 14)
            begin
                b.sync_header = SYNC_OS;
                if (pl[7:0] == SKIP_FIRST)
                    pl[0] = ~pl[0];
            end
            else if (pick < 20)
                b.sync_header = $urandom_range(0, 1) ? SyncErrHigh : SyncErrLow;
            else if (pick < 25)
            begin
                b.sync_header = 2'($urandom_range(0, 3));
                if ($urandom_range(0, 1))
                    pl[7:0] = SKIP_FIRST;
            end
            else
                b.sync_header = SYNC_DATA;
            b.payload_low  = pl[HalfBits-1:0];
            b.payload_high = pl[PayloadBits-1:HalfBits];
            if (n == NumRandom - CalmTail)
                calm = 1'b1;
            if (n % 50 == 0)
                src_gap_pct = burst_odds();
            send_block(b);
            source_gap();
        end
        blk_in_bus.valid = 1'b0;

        while (pending_blocks.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("%0d blocks in, %0d results checked: %0d data, %0d unlocked data, %0d error,",
                 beats_in, beats_out, kind_seen[KIND_DATA], kind_seen[KIND_DATA_UNLOCKED],
                 kind_seen[KIND_ERROR]);
        $display("%0d ordered sets of which %0d skip sets, %0d mismatches",
                 kind_seen[KIND_ORDERED_SET], skips_seen, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
